### rtl/core/twdfs_pkg.sv
// ----------------------------------------------------------------------------
// Two-wire display frame sender package
// Frame constants, widths and sequencer codes shared by the sender and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package twdfs_pkg;

   // Number of segment bytes sent in the data transfer.
   localparam int DIGIT_COUNT = 4;
   // Digit inputs present on the request word.
   localparam int DIGIT_INPUTS = 4;

   localparam int BYTE_IDX_W  = $clog2(DIGIT_COUNT + 1);
   localparam int DIGIT_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   localparam logic [7:0] CMD_WRITE_DATA   = 8'h40;
   localparam logic [7:0] CMD_ADDRESS      = 8'hC0;
   localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h8F;

   // Request kind carried in tuser.
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Position inside a start or stop condition.
   localparam logic [1:0] COND_STEP_0 = 2'd0;
   localparam logic [1:0] COND_STEP_1 = 2'd1;
   localparam logic [1:0] COND_STEP_2 = 2'd2;
   localparam logic [1:0] COND_STEP_3 = 2'd3;

   // Phase of one bit clock inside a byte.
   localparam logic [1:0] PHASE_CLK_LOW  = 2'd0;
   localparam logic [1:0] PHASE_DATA     = 2'd1;
   localparam logic [1:0] PHASE_CLK_HIGH = 2'd2;

   // Bit counter value of the acknowledge clock that follows bit 7.
   localparam logic [3:0] BIT_ACK = 4'd8;

   // Response word bit positions.
   localparam int RSP_CLK   = 0;
   localparam int RSP_DIO   = 1;
   localparam int RSP_BUSY  = 2;
   localparam int RSP_ACC   = 3;
   localparam int RSP_DONE  = 4;

   typedef enum logic [2:0] {
      SEG_START = 3'b001,
      SEG_BYTE  = 3'b010,
      SEG_STOP  = 3'b100
   } seg_type;

   typedef enum logic [2:0] {
      XFER_CMD  = 3'b001,
      XFER_DATA = 3'b010,
      XFER_CTRL = 3'b100
   } xfer_type;

endpackage

`default_nettype wire

### rtl/core/two_wire_display_frame_sender.sv
// ----------------------------------------------------------------------------
// Two-wire display frame sender
// Sequences the clock and data pin levels of a two-wire LED display driver.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries one word per item. tuser is the command: a
// load word stores the four segment bytes from tdata and starts a frame, a
// tick word performs one pin write of the running frame. A frame is start,
// 0x40, stop; start, 0xC0, the segment bytes, stop; start, 0x8F, stop, which
// is 213 pin writes for four digits. Bytes go out least significant bit
// first, each followed by an acknowledge clock with data held high.
// Every request word yields exactly one response word with the pin levels
// after the item, the busy flag, a load-accepted flag and end of frame.
// A load while a frame is running is ignored. Ticks while idle change nothing.
// The response is valid in the cycle after request acceptance, and one word
// is accepted every cycle unless the receiver stalls: each tick is decoded
// from small segment, bit and phase counters in one pass into the response
// register. When the receiver stalls, the response register holds its word
// and req_tready follows rsp_tready, so nothing is lost or repeated.
// Synchronous reset returns both pins high, clears busy and empties the
// response register; the segment store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module two_wire_display_frame_sender (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata fields from bit 0: digit_0[7:0], digit_1, digit_2, digit_3.
   input  wire logic [31:0] req_tdata,
   // tuser fields from bit 0: command.
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata fields from bit 0: clk_level, dio_level, busy_res, accepted,
   // frame_done, then three zero bits.
   output logic [7:0]       rsp_tdata
);

   // Sequencer state. The segment says whether a start condition, a byte
   // or a stop condition is on the pins; the transfer says which of the
   // three transfers of the frame is running.
   twdfs_pkg::seg_type  seg_ff, seg_in;
   twdfs_pkg::xfer_type xfer_ff, xfer_in;
   logic [1:0]  cond_ff, cond_in;
   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [twdfs_pkg::BYTE_IDX_W-1:0] byte_ff, byte_in;
   logic        clk_ff, clk_in;
   logic        dio_ff, dio_in;
   logic        busy_ff, busy_in;

   logic [7:0]  store_ff [twdfs_pkg::DIGIT_COUNT];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        load_go;
   logic        accepted;
   logic        done;
   logic [7:0]  byte_val;
   logic [twdfs_pkg::BYTE_IDX_W-1:0]  digit_sel;

   // The response register frees up when it is empty or being taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign load_go    = req_fire && (req_tuser[0] == twdfs_pkg::REQ_LOAD) && !busy_ff;

   // Byte currently being shifted out. In the data transfer byte 0 is the
   // address command and bytes 1 and up come from the segment store.
   assign digit_sel = byte_ff - twdfs_pkg::BYTE_IDX_W'(1);

   always_comb begin
      case (xfer_ff)
         twdfs_pkg::XFER_CMD: begin
            byte_val = twdfs_pkg::CMD_WRITE_DATA;
         end
         twdfs_pkg::XFER_DATA: begin
            if (byte_ff == '0) begin
               byte_val = twdfs_pkg::CMD_ADDRESS;
            end else begin
               byte_val = store_ff[digit_sel[twdfs_pkg::DIGIT_IDX_W-1:0]];
            end
         end
         default: begin
            byte_val = twdfs_pkg::CMD_DISPLAY_CTRL;
         end
      endcase
   end

   always_comb begin
      seg_in   = seg_ff;
      xfer_in  = xfer_ff;
      cond_in  = cond_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      clk_in   = clk_ff;
      dio_in   = dio_ff;
      busy_in  = busy_ff;
      accepted = 1'b0;
      done     = 1'b0;

      if (load_go) begin
         seg_in   = twdfs_pkg::SEG_START;
         xfer_in  = twdfs_pkg::XFER_CMD;
         cond_in  = twdfs_pkg::COND_STEP_0;
         phase_in = twdfs_pkg::PHASE_CLK_LOW;
         bit_in   = '0;
         byte_in  = '0;
         busy_in  = 1'b1;
         accepted = 1'b1;
      end else if (req_fire && (req_tuser[0] == twdfs_pkg::REQ_TICK) && busy_ff) begin
         case (seg_ff)
            twdfs_pkg::SEG_START: begin
               // Data falls while the clock is high, then the clock drops.
               case (cond_ff)
                  twdfs_pkg::COND_STEP_0: dio_in = 1'b1;
                  twdfs_pkg::COND_STEP_1: clk_in = 1'b1;
                  twdfs_pkg::COND_STEP_2: dio_in = 1'b0;
                  default:                clk_in = 1'b0;
               endcase
               cond_in = cond_ff + 2'd1;
               if (cond_ff == twdfs_pkg::COND_STEP_3) begin
                  seg_in   = twdfs_pkg::SEG_BYTE;
                  phase_in = twdfs_pkg::PHASE_CLK_LOW;
                  bit_in   = '0;
               end
            end
            twdfs_pkg::SEG_BYTE: begin
               case (phase_ff)
                  twdfs_pkg::PHASE_CLK_LOW: begin
                     clk_in   = 1'b0;
                     phase_in = twdfs_pkg::PHASE_DATA;
                  end
                  twdfs_pkg::PHASE_DATA: begin
                     // The acknowledge clock releases data high.
                     dio_in   = (bit_ff == twdfs_pkg::BIT_ACK) ? 1'b1 : byte_val[bit_ff[2:0]];
                     phase_in = twdfs_pkg::PHASE_CLK_HIGH;
                  end
                  default: begin
                     clk_in   = 1'b1;
                     phase_in = twdfs_pkg::PHASE_CLK_LOW;
                     bit_in   = bit_ff + 4'd1;
                     if (bit_ff == twdfs_pkg::BIT_ACK) begin
                        bit_in = '0;
                        if ((xfer_ff == twdfs_pkg::XFER_DATA) &&
                            (byte_ff != twdfs_pkg::BYTE_IDX_W'(twdfs_pkg::DIGIT_COUNT))) begin
                           byte_in = byte_ff + twdfs_pkg::BYTE_IDX_W'(1);
                        end else begin
                           seg_in  = twdfs_pkg::SEG_STOP;
                           cond_in = twdfs_pkg::COND_STEP_0;
                        end
                     end
                  end
               endcase
            end
            default: begin
               // Stop: data rises while the clock is high.
               case (cond_ff)
                  twdfs_pkg::COND_STEP_0: clk_in = 1'b0;
                  twdfs_pkg::COND_STEP_1: dio_in = 1'b0;
                  twdfs_pkg::COND_STEP_2: clk_in = 1'b1;
                  default:                dio_in = 1'b1;
               endcase
               cond_in = cond_ff + 2'd1;
               if (cond_ff == twdfs_pkg::COND_STEP_3) begin
                  seg_in  = twdfs_pkg::SEG_START;
                  byte_in = '0;
                  case (xfer_ff)
                     twdfs_pkg::XFER_CMD:  xfer_in = twdfs_pkg::XFER_DATA;
                     twdfs_pkg::XFER_DATA: xfer_in = twdfs_pkg::XFER_CTRL;
                     default: begin
                        busy_in = 1'b0;
                        done    = 1'b1;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (req_fire) begin
         rsp_data_in = '0;
         rsp_data_in[twdfs_pkg::RSP_CLK]  = clk_in;
         rsp_data_in[twdfs_pkg::RSP_DIO]  = dio_in;
         rsp_data_in[twdfs_pkg::RSP_BUSY] = busy_in;
         rsp_data_in[twdfs_pkg::RSP_ACC]  = accepted;
         rsp_data_in[twdfs_pkg::RSP_DONE] = done;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= twdfs_pkg::SEG_START;
         xfer_ff      <= twdfs_pkg::XFER_CMD;
         cond_ff      <= twdfs_pkg::COND_STEP_0;
         phase_ff     <= twdfs_pkg::PHASE_CLK_LOW;
         bit_ff       <= '0;
         byte_ff      <= '0;
         clk_ff       <= 1'b1;
         dio_ff       <= 1'b1;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         xfer_ff      <= xfer_in;
         cond_ff      <= cond_in;
         phase_ff     <= phase_in;
         bit_ff       <= bit_in;
         byte_ff      <= byte_in;
         clk_ff       <= clk_in;
         dio_ff       <= dio_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Segment bytes and the response word carry no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (load_go) begin
         for (int i = 0; i < twdfs_pkg::DIGIT_COUNT; i++) begin
            // Positions without an input are sent blank.
            if (i < twdfs_pkg::DIGIT_INPUTS) begin
               store_ff[i] <= req_tdata[8*i +: 8];
            end else begin
               store_ff[i] <= 8'h00;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/core/twdfs_checker.sv
// ----------------------------------------------------------------------------
// Two-wire display frame sender checker
// Port-level properties of the sender, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module twdfs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata
);

   // A stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // An empty response register always takes a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty response register");

   // A started frame reports busy and cannot be done at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[twdfs_pkg::RSP_ACC] |->
         rsp_tdata[twdfs_pkg::RSP_BUSY] && !rsp_tdata[twdfs_pkg::RSP_DONE])
      else $error("accepted load without busy");

   // End of frame leaves both pins high and clears busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[twdfs_pkg::RSP_DONE] |->
         !rsp_tdata[twdfs_pkg::RSP_BUSY] && rsp_tdata[twdfs_pkg::RSP_CLK] &&
         rsp_tdata[twdfs_pkg::RSP_DIO])
      else $error("frame end with wrong pin state");

   // Reset empties the response register.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind two_wire_display_frame_sender twdfs_checker u_twdfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### test/tb_two_wire_display_frame_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-wire display frame sender testbench
// Sends load and tick words, forecasts pin levels and compares every response.
// ----------------------------------------------------------------------------
// A load word stores the segment bytes and starts a frame. Each tick word then
// advances the frame by one pin write. The stimulus is mostly complete frames
// with random segment bytes, with two kinds of noise mixed in: loads while a
// frame is running, which must be ignored, and ticks while idle, which must
// change nothing. A cycle-free model of the pin sequencer runs on every
// accepted request word and queues the response word it should produce. The
// monitor checks each response word against the oldest queued forecast.
// ----------------------------------------------------------------------------

module tb_two_wire_display_frame_sender;

   // One frame is three transfers. The data transfer carries the address byte
   // and one byte per display position.
   localparam int COND_WRITES  = 4;
   localparam int BYTE_WRITES  = 27;
   localparam int FRAME_WRITES = 105 + 27 * twdfs_pkg::DIGIT_COUNT;

   localparam int ITEM_BUDGET    = 1300;
   localparam int TAIL_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   // A request word as the generator builds it. digits holds digit_0 in the
   // low byte, which is also the layout of req_tdata.
   typedef struct packed {
      logic        command;
      logic [31:0] digits;
   } display_item_type;

   // The fields of one response word.
   typedef struct packed {
      logic clk_level;
      logic dio_level;
      logic busy_res;
      logic accepted;
      logic frame_done;
   } pin_report_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = twdfs_pkg::REQ_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   two_wire_display_frame_sender DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Words waiting to be sent and response words still to come.
   display_item_type display_item_q[$];
   pin_report_type   pin_forecast_q[$];

   display_item_type current_item;
   pin_report_type   wanted_report;
   int               words_sent    = 0;
   int               total_words   = 0;
   int               counted_items = 0;
   int               error_count   = 0;
   int               quiet_cycles  = 0;

   // ------------------------------------------------------------------------
   // Pin sequencer model. It keeps its own copy of the segment store, the
   // write index, both pin levels and the busy flag.
   // ------------------------------------------------------------------------
   logic [7:0]  seg_copy [twdfs_pkg::DIGIT_COUNT] = '{default: 8'h00};
   int unsigned write_index = 0;
   logic        clk_model   = 1'b1;
   logic        dio_model   = 1'b1;
   logic        busy_model  = 1'b0;

   // A start condition pulls data low while the clock is high; a stop
   // condition releases data while the clock is high.
   function automatic void drive_condition(input bit opening, input int k);
      if (opening) begin
         case (k)
            0: dio_model = 1'b1;
            1: clk_model = 1'b1;
            2: dio_model = 1'b0;
            default: clk_model = 1'b0;
         endcase
      end else begin
         case (k)
            0: clk_model = 1'b0;
            1: dio_model = 1'b0;
            2: clk_model = 1'b1;
            default: dio_model = 1'b1;
         endcase
      end
   endfunction

   // Eight bit clocks, least significant bit first, then an acknowledge clock
   // with data released high.
   function automatic void drive_byte(input logic [7:0] value, input int k);
      if (k < 24) begin
         case (k % 3)
            0: clk_model = 1'b0;
            1: dio_model = value[k / 3];
            default: clk_model = 1'b1;
         endcase
      end else if (k == 24) begin
         clk_model = 1'b0;
      end else if (k == 25) begin
         dio_model = 1'b1;
      end else begin
         clk_model = 1'b1;
      end
   endfunction

   // Performs pin write number k of the frame by walking the three transfers.
   function automatic void drive_frame_write(input int k);
      int pos;
      int slot;
      pos = k;
      if (pos < COND_WRITES) begin
         drive_condition(1'b1, pos);
         return;
      end
      pos -= COND_WRITES;
      if (pos < BYTE_WRITES) begin
         drive_byte(twdfs_pkg::CMD_WRITE_DATA, pos);
         return;
      end
      pos -= BYTE_WRITES;
      if (pos < COND_WRITES) begin
         drive_condition(1'b0, pos);
         return;
      end
      pos -= COND_WRITES;

      if (pos < COND_WRITES) begin
         drive_condition(1'b1, pos);
         return;
      end
      pos -= COND_WRITES;
      if (pos < BYTE_WRITES * (twdfs_pkg::DIGIT_COUNT + 1)) begin
         slot = pos / BYTE_WRITES;
         if (slot == 0) begin
            drive_byte(twdfs_pkg::CMD_ADDRESS, pos % BYTE_WRITES);
         end else begin
            drive_byte(seg_copy[slot - 1], pos % BYTE_WRITES);
         end
         return;
      end
      pos -= BYTE_WRITES * (twdfs_pkg::DIGIT_COUNT + 1);
      if (pos < COND_WRITES) begin
         drive_condition(1'b0, pos);
         return;
      end
      pos -= COND_WRITES;

      if (pos < COND_WRITES) begin
         drive_condition(1'b1, pos);
         return;
      end
      pos -= COND_WRITES;
      if (pos < BYTE_WRITES) begin
         drive_byte(twdfs_pkg::CMD_DISPLAY_CTRL, pos);
         return;
      end
      pos -= BYTE_WRITES;
      if (pos < COND_WRITES) begin
         drive_condition(1'b0, pos);
      end
   endfunction

   // Advances the model by one accepted request word and returns the
   // response word it must produce.
   function automatic pin_report_type forecast_pins(input display_item_type item);
      pin_report_type report;
      report = '0;
      if (item.command == twdfs_pkg::REQ_LOAD) begin
         // A load while a frame is running is dropped without a trace.
         if (!busy_model) begin
            for (int i = 0; i < twdfs_pkg::DIGIT_COUNT; i++) begin
               seg_copy[i] = (i < twdfs_pkg::DIGIT_INPUTS) ?
                             item.digits[8 * i +: 8] : 8'h00;
            end
            write_index = 0;
            busy_model  = 1'b1;
            report.accepted = 1'b1;
         end
      end else if (busy_model) begin
         drive_frame_write(write_index);
         write_index++;
         if (write_index >= FRAME_WRITES) begin
            write_index = 0;
            busy_model  = 1'b0;
            report.frame_done = 1'b1;
         end
      end
      report.clk_level = clk_model;
      report.dio_level = dio_model;
      report.busy_res  = busy_model;
      return report;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus building. Words that the block does not act on (idle ticks and
   // loads during a frame) are not counted against the item budget.
   // ------------------------------------------------------------------------
   task automatic push_word(input logic command, input logic [31:0] digits,
                            input bit counts);
      display_item_type item;
      item.command = command;
      item.digits  = digits;
      display_item_q.push_back(item);
      if (counts) begin
         counted_items++;
      end
   endtask

   // A full frame: the load, then one tick per pin write. Stray loads are
   // sprinkled in while ticks are still outstanding, so they always land on
   // a busy block. With edge_loads set, a stray load also follows the
   // starting load directly and precedes the final tick.
   task automatic push_frame(input logic [31:0] digits, input int stray_pct,
                             input bit edge_loads);
      push_word(twdfs_pkg::REQ_LOAD, digits, 1'b1);
      if (edge_loads) begin
         push_word(twdfs_pkg::REQ_LOAD, ~digits, 1'b0);
      end
      for (int t = 0; t < FRAME_WRITES; t++) begin
         push_word(twdfs_pkg::REQ_TICK, $urandom(), 1'b1);
         if (t < FRAME_WRITES - 1) begin
            if ((edge_loads && t == FRAME_WRITES - 2) ||
                $urandom_range(99) < stray_pct) begin
               push_word(twdfs_pkg::REQ_LOAD, $urandom(), 1'b0);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Idling profile. The first third of the words runs with a slow sender
   // and a stalling receiver, the second third swaps the two, and the last
   // third runs with neither side idling.
   // ------------------------------------------------------------------------
   function automatic int sender_idle_pct();
      int third;
      third = (total_words == 0) ? 0 : (words_sent * 3) / total_words;
      case (third)
         0: return 19;
         1: return 61;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      int third;
      third = (total_words == 0) ? 0 : (words_sent * 3) / total_words;
      case (third)
         0: return 61;
         1: return 19;
         default: return 0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Driver. A word is accepted at the edge where req_tvalid and req_tready
   // are both high; at that edge it goes through the model. A new word is
   // offered only when the channel is empty or the current word just went
   // through, so valid is never withdrawn before its handshake.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pin_forecast_q.push_back(forecast_pins(current_item));
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (display_item_q.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct()) begin
               current_item = display_item_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= current_item.digits;
               req_tuser  <= current_item.command;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. Every response word taken is compared field by field with the
   // oldest forecast. The ready line is redrawn on every cycle.
   // ------------------------------------------------------------------------
   task automatic compare_field(input string field, input logic wanted,
                                input logic seen);
      if (seen !== wanted) begin
         $display("%0t: %s mismatch, expected %b, actual %b",
                  $time, field, wanted, seen);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pin_forecast_q.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               wanted_report = pin_forecast_q.pop_front();
               compare_field("clk_level",  wanted_report.clk_level,
                             rsp_tdata[twdfs_pkg::RSP_CLK]);
               compare_field("dio_level",  wanted_report.dio_level,
                             rsp_tdata[twdfs_pkg::RSP_DIO]);
               compare_field("busy_res",   wanted_report.busy_res,
                             rsp_tdata[twdfs_pkg::RSP_BUSY]);
               compare_field("accepted",   wanted_report.accepted,
                             rsp_tdata[twdfs_pkg::RSP_ACC]);
               compare_field("frame_done", wanted_report.frame_done,
                             rsp_tdata[twdfs_pkg::RSP_DONE]);
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog. A run of cycles with no word moving on either channel means
   // the block is stuck.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of test.
   // ------------------------------------------------------------------------
   initial begin
      // Directed part. A tick right after reset must leave both pins high.
      push_word(twdfs_pkg::REQ_TICK, 32'hFFFF_FFFF, 1'b0);
      // All-zero segment bytes, with loads arriving right after the starting
      // load and right before the final tick.
      push_frame(32'h0000_0000, 0, 1'b1);
      // An idle tick after the frame has finished.
      push_word(twdfs_pkg::REQ_TICK, 32'h0000_0000, 1'b0);
      // All-ones segment bytes, then a new frame loaded directly on the word
      // after the final tick, with single set bits at both byte edges.
      push_frame(32'hFFFF_FFFF, 0, 1'b1);
      push_frame(32'h8001_5AA5, 0, 1'b0);

      // Random part: frames with random segment bytes, stray loads during
      // the frame, and a few idle ticks between frames. A frame is added
      // only while it still fits in the budget.
      while (counted_items + FRAME_WRITES + 1 <= ITEM_BUDGET) begin
         repeat ($urandom_range(3)) begin
            push_word(twdfs_pkg::REQ_TICK, $urandom(), 1'b0);
         end
         push_frame($urandom(), 3, $urandom_range(3) == 0);
      end
      total_words = display_item_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait until every word has gone in and every response has come out,
      // then give the block a few more cycles to show any stray word.
      do begin
         @(posedge clock);
      end while (words_sent < total_words || pin_forecast_q.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
